// ----- design/sorted_deadline_timer_queue_macros.svh -----
// Assertion helpers for the timer queue.
`ifndef SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH
`define SORTED_DEADLINE_TIMER_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SDTQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDTQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sdtq_pkg.sv -----
`default_nettype none

package sdtq_pkg;

    localparam int unsigned HANDLE_BITS  = 10;
    localparam int unsigned TIME_BITS    = 32;
    localparam int unsigned RESULT_LIMIT = 32;
    localparam int unsigned RES_CNT_W    = $clog2(RESULT_LIMIT);
    localparam logic [RES_CNT_W-1:0] LAST_RESULT_IDX = RES_CNT_W'(RESULT_LIMIT - 1);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_ADJUST = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_TICK   = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_NONE     = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DUP      = 3'd5
    } status_t;

    typedef struct packed {
        mode_t                  mode;
        logic [HANDLE_BITS-1:0] handle;
        logic [TIME_BITS-1:0]   time_value;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic [HANDLE_BITS-1:0] expired_handle;
        logic                   last;
    } out_item_t;

    // One queue slot.
    typedef struct packed {
        logic [TIME_BITS-1:0]   expiry;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_REMOVE = 2'd2,
        CELL_POP    = 2'd3
    } cell_op_t;

    // Broadcast to every cell.
    typedef struct packed {
        cell_op_t               op;
        logic [TIME_BITS-1:0]   key_time;
        logic [HANDLE_BITS-1:0] key_handle;
    } cell_ctl_t;

    // Per-cell flags back to the controller and the right neighbor.
    typedef struct packed {
        logic match;
        logic later;
        logic due;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- design/sorted_deadline_timer_queue.sv -----
// Sorted deadline timer queue: up to CAPACITY timer handles held in a row of cells in
// ascending expiry order, equal expiries kept in arrival order. Items arrive on the s_
// channel (insert, adjust, delete, tick) and results leave on the m_ channel; one item is
// worked at a time. Insert, adjust and delete each give one result: insert runs an insert
// pass, delete a remove pass, adjust a remove pass then an insert pass, and a duplicate,
// full or not-found reply needs no pass; a result may wait for the output register. A tick
// gives one result per expired handle (at most 32 per tick, the rest stay queued for a later
// tick) while the output register can take it, or one none result when nothing is due;
// each expired handle leaves the head cell as the whole row shifts one place left.
// Handle lookup is a parallel compare in every cell done in the transfer cycle. Times
// compare unsigned, without wrap. The s_ channel is not ready while reset is held.
`default_nettype none
`include "sorted_deadline_timer_queue_macros.svh"

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int unsigned CAPACITY = 32
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_payload,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_payload
);

    localparam int unsigned POS_W = $clog2(CAPACITY);
    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REMOVE = 5'b00010,
        S_INSERT = 5'b00100,
        S_TICK   = 5'b01000,
        S_REPLY  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [RES_CNT_W-1:0]   n_reg, n_next;
    status_t                status_reg, status_next;
    logic [POS_W-1:0]       pos_reg, pos_next;

    // captured item
    mode_t                  mode_reg;
    logic [HANDLE_BITS-1:0] handle_reg;
    logic [TIME_BITS-1:0]   time_reg;

    // output register
    logic                   m_valid_reg;
    out_item_t              m_payload_reg;
    logic                   out_free;
    logic                   out_load;

    // result of this cycle
    logic                   res_valid;
    status_t                res_status;
    logic [HANDLE_BITS-1:0] res_handle;
    logic                   res_last;

    // cell row
    cell_ctl_t              ctl;
    cell_op_t               cell_op;
    entry_t                 cell_entry [CAPACITY];
    cell_stat_t             cell_stat  [CAPACITY];
    logic [CAPACITY-1:0]    occ;
    logic                   found;
    logic [POS_W-1:0]       found_pos;
    logic                   queue_full;
    logic                   head_due;
    logic                   next_due;
    logic                   accept;

    assign s_ready  = aresetn && (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // In idle the cells look up the arriving handle directly; later passes use the copy.
    assign ctl.op         = cell_op;
    assign ctl.key_time   = (state_reg == S_IDLE) ? s_payload.time_value : time_reg;
    assign ctl.key_handle = (state_reg == S_IDLE) ? s_payload.handle : handle_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            entry_t left_e;
            entry_t right_e;
            logic   left_l;

            assign occ[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0) begin : g_first
                assign left_e = '0;
                assign left_l = 1'b0;
            end else begin : g_mid
                assign left_e = cell_entry[gi-1];
                assign left_l = cell_stat[gi-1].later;
            end

            if (gi == CAPACITY - 1) begin : g_end
                assign right_e = '0;
            end else begin : g_inner
                assign right_e = cell_entry[gi+1];
            end

            sdtq_cell #(
                .IDX   (gi),
                .POS_W (POS_W)
            ) u_cell (
                .aclk        (aclk),
                .ctl         (ctl),
                .remove_pos  (pos_reg),
                .occupied    (occ[gi]),
                .left_later  (left_l),
                .left_entry  (left_e),
                .right_entry (right_e),
                .entry       (cell_entry[gi]),
                .stat        (cell_stat[gi])
            );
        end
    endgenerate

    // Handles are unique in the queue, so at most one match: OR the indexes together.
    always_comb begin
        found     = 1'b0;
        found_pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (cell_stat[i].match) begin
                found     = 1'b1;
                found_pos = found_pos | POS_W'(i);
            end
        end
    end

    assign queue_full = (count_reg == CNT_W'(CAPACITY));
    assign head_due   = cell_stat[0].due;
    assign next_due   = cell_stat[1].due;

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        n_next      = n_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        cell_op     = CELL_HOLD;
        res_valid   = 1'b0;
        res_status  = ST_OK;
        res_handle  = '0;
        res_last    = 1'b1;
        out_load    = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    pos_next = found_pos;
                    unique case (s_payload.mode)
                        MODE_INSERT: begin
                            // duplicate check ranks ahead of the full check
                            if (found) begin
                                res_valid  = 1'b1;
                                res_status = ST_DUP;
                            end else if (queue_full) begin
                                res_valid  = 1'b1;
                                res_status = ST_FULL;
                            end else begin
                                state_next = S_INSERT;
                            end
                        end
                        MODE_ADJUST, MODE_DELETE: begin
                            if (!found) begin
                                res_valid  = 1'b1;
                                res_status = ST_NOTFOUND;
                            end else begin
                                state_next = S_REMOVE;
                            end
                        end
                        MODE_TICK: begin
                            state_next = S_TICK;
                            n_next     = '0;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                // close the gap at the matched slot
                cell_op    = CELL_REMOVE;
                count_next = count_reg - CNT_W'(1);
                if (mode_reg == MODE_ADJUST) begin
                    state_next = S_INSERT;
                end else begin
                    res_valid = 1'b1;
                end
            end
            S_INSERT: begin
                cell_op    = CELL_INSERT;
                count_next = count_reg + CNT_W'(1);
                res_valid  = 1'b1;
            end
            S_TICK: begin
                // one expiry per cycle, only when the output register can take it
                if (out_free) begin
                    res_valid = 1'b1;
                    if (head_due) begin
                        cell_op    = CELL_POP;
                        count_next = count_reg - CNT_W'(1);
                        n_next     = n_reg + RES_CNT_W'(1);
                        res_status = ST_EXPIRED;
                        res_handle = cell_entry[0].handle;
                        res_last   = !next_due || (n_reg == LAST_RESULT_IDX);
                    end else begin
                        res_status = ST_NONE;
                    end
                end
            end
            S_REPLY: begin
                res_valid  = 1'b1;
                res_status = status_reg;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Hand the result to the output register, or park it until there is room.
        if (res_valid) begin
            if (out_free) begin
                out_load   = 1'b1;
                state_next = (state_reg == S_TICK && !res_last) ? S_TICK : S_IDLE;
            end else begin
                status_next = res_status;
                state_next  = S_REPLY;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and working registers, no reset needed
    always_ff @(posedge aclk) begin
        n_reg      <= n_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
        if (accept) begin
            mode_reg   <= s_payload.mode;
            handle_reg <= s_payload.handle;
            time_reg   <= s_payload.time_value;
        end
        if (out_load) begin
            m_payload_reg.status         <= res_status;
            m_payload_reg.expired_handle <= res_handle;
            m_payload_reg.last           <= res_last;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // ---- checks ----
    `SDTQ_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(CAPACITY), "occupancy over capacity")
    `SDTQ_ASSERT_NOW(a_insert_room, cell_op == CELL_INSERT, !queue_full, "insert into full row")
    `SDTQ_ASSERT_NEXT(a_pop_count, cell_op == CELL_POP, count_reg == $past(count_reg) - CNT_W'(1), "pop did not drop count")
    `SDTQ_ASSERT_NOW(a_mid_expired, m_valid && !m_payload.last, m_payload.status == ST_EXPIRED, "non-final result not an expiry")

endmodule

`default_nettype wire

// ----- design/sdtq_cell.sv -----
`default_nettype none

module sdtq_cell
    import sdtq_pkg::*;
#(
    parameter int unsigned IDX   = 0,
    parameter int unsigned POS_W = 5
) (
    input  wire logic             aclk,
    input  wire cell_ctl_t        ctl,
    input  wire logic [POS_W-1:0] remove_pos,
    input  wire logic             occupied,
    input  wire logic             left_later,
    input  wire entry_t           left_entry,
    input  wire entry_t           right_entry,
    output entry_t                entry,
    output cell_stat_t            stat
);

    entry_t entry_reg;
    entry_t entry_next;
    entry_t new_entry;

    assign new_entry = '{expiry: ctl.key_time, handle: ctl.key_handle};

    assign stat.match = occupied && (entry_reg.handle == ctl.key_handle);
    assign stat.later = occupied && (entry_reg.expiry > ctl.key_time);
    assign stat.due   = occupied && (entry_reg.expiry <= ctl.key_time);

    always_comb begin
        entry_next = entry_reg;
        unique case (ctl.op)
            CELL_HOLD: begin
                entry_next = entry_reg;
            end
            CELL_INSERT: begin
                // shift right past the insertion point, else take the new slot
                if (left_later) begin
                    entry_next = left_entry;
                end else if (stat.later || !occupied) begin
                    entry_next = new_entry;
                end
            end
            CELL_REMOVE: begin
                if (POS_W'(IDX) >= remove_pos) begin
                    entry_next = right_entry;
                end
            end
            CELL_POP: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ----- test/tb_sorted_deadline_timer_queue.sv -----
module tb_sorted_deadline_timer_queue;
    import sdtq_pkg::*;

    localparam int unsigned QUEUE_DEPTH   = 32;
    localparam int unsigned TOTAL_ITEMS   = 425;   // all items sent, directed and random together
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef logic [HANDLE_BITS-1:0] handle_t;
    typedef logic [TIME_BITS-1:0]   stamp_t;

    // Shadow copy of the timer list plus the results it still owes the DUT.
    class timer_list_shadow;
        entry_t    armed[$];   // ascending expiry, ties in arrival order
        out_item_t owed[$];    // expected results, oldest first
        int        mismatches = 0;

        function int find_handle(handle_t h);
            foreach (armed[i]) if (armed[i].handle == h) return i;
            return -1;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Goes behind every entry with the same or an earlier expiry.
        function void file_sorted(handle_t h, stamp_t t);
            int     pos;
            entry_t e;
            pos = 0;
            while (pos < armed.size() && armed[pos].expiry <= t) pos++;
            e.expiry = t;
            e.handle = h;
            armed.insert(pos, e);
        endfunction

        function void owe(status_t st, handle_t h, logic last);
            out_item_t r;
            r.status         = st;
            r.expired_handle = h;
            r.last           = last;
            owed.push_back(r);
        endfunction

        function void take_command(in_item_t cmd);
            int pos;
            int n;
            pos = find_handle(cmd.handle);
            case (cmd.mode)
                MODE_INSERT: begin
                    // duplicate check wins over the full check
                    if (pos >= 0) begin
                        owe(ST_DUP, '0, 1'b1);
                    end else if (armed.size() >= QUEUE_DEPTH) begin
                        owe(ST_FULL, '0, 1'b1);
                    end else begin
                        file_sorted(cmd.handle, cmd.time_value);
                        owe(ST_OK, '0, 1'b1);
                    end
                end
                MODE_ADJUST: begin
                    if (pos < 0) begin
                        owe(ST_NOTFOUND, '0, 1'b1);
                    end else begin
                        armed.delete(pos);
                        file_sorted(cmd.handle, cmd.time_value);
                        owe(ST_OK, '0, 1'b1);
                    end
                end
                MODE_DELETE: begin
                    if (pos < 0) begin
                        owe(ST_NOTFOUND, '0, 1'b1);
                    end else begin
                        armed.delete(pos);
                        owe(ST_OK, '0, 1'b1);
                    end
                end
                default: begin
                    n = 0;
                    while (n < RESULT_LIMIT && armed.size() > 0 &&
                           armed[0].expiry <= cmd.time_value) begin
                        owe(ST_EXPIRED, armed[0].handle, 1'b0);
                        void'(armed.pop_front());
                        n++;
                    end
                    if (n == 0) begin
                        owe(ST_NONE, '0, 1'b1);
                    end else begin
                        owed[owed.size() - 1].last = 1'b1;
                    end
                end
            endcase
        endfunction

        function void note_miss(string msg);
            mismatches++;
            if (mismatches <= 10) $display("[%0t] %s", $time, msg);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (owed.size() == 0) begin
                note_miss($sformatf("unexpected result: status=%0d handle=%0d last=%0d",
                                    got.status, got.expired_handle, got.last));
                return;
            end
            want = owed.pop_front();
            if (got.status !== want.status || got.expired_handle !== want.expired_handle ||
                got.last !== want.last) begin
                note_miss($sformatf({"result mismatch: expected status=%0d handle=%0d last=%0d,",
                                     " got status=%0d handle=%0d last=%0d"},
                                    want.status, want.expired_handle, want.last,
                                    got.status, got.expired_handle, got.last));
            end
        endfunction
    endclass

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_payload;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_payload;

    timer_list_shadow shadow = new;

    bit     steady = 1'b0;   // while set, neither side inserts idle cycles
    int     items_sent = 0;
    stamp_t now = '0;        // running "current time" used for ticks and expiries

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    sorted_deadline_timer_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    // Both channels are sampled in one process, input first, so a command's
    // expected results are always queued before any of its results is checked.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) shadow.take_command(s_payload);
            if (m_valid && m_ready) shadow.check_result(m_payload);
        end
    end

    // Idle length: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic handle_t fresh_handle();
        handle_t h;
        do h = handle_t'($urandom); while (shadow.find_handle(h) >= 0);
        return h;
    endfunction

    function automatic handle_t queued_handle();
        if (shadow.armed.size() == 0) return handle_t'($urandom);
        return shadow.armed[$urandom_range(0, shadow.armed.size() - 1)].handle;
    endfunction

    // Near-future expiries mostly; some full-range values and some exact ties.
    function automatic stamp_t pick_expiry();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return stamp_t'($urandom);
        if (r < 25 && shadow.armed.size() > 0)
            return shadow.armed[$urandom_range(0, shadow.armed.size() - 1)].expiry;
        return now + $urandom_range(0, 400);
    endfunction

    // One transfer on the s_ channel. Valid stays up across back-to-back items.
    task automatic send_cmd(mode_t mode, handle_t h, stamp_t t);
        in_item_t cmd;
        int       gap;
        cmd.mode       = mode;
        cmd.handle     = h;
        cmd.time_value = t;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= cmd;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Sender holds off until every owed result has come back.
    task automatic wait_all_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (shadow.pending() > 0);
    endtask

    // Fill to capacity, hit the full case, then expire everything in one tick.
    task automatic fill_then_drain();
        while (shadow.armed.size() < QUEUE_DEPTH)
            send_cmd(MODE_INSERT, fresh_handle(), pick_expiry());
        send_cmd(MODE_INSERT, fresh_handle(), now);             // full
        send_cmd(MODE_INSERT, queued_handle(), now);            // duplicate beats full
        send_cmd(MODE_ADJUST, queued_handle(), pick_expiry());  // adjust inside a full list
        send_cmd(MODE_TICK, handle_t'($urandom), '1);           // max results from one tick
        wait_all_results();
    endtask

    // Mostly well-formed traffic on queued handles, some misses and noise.
    task automatic random_timer_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            send_cmd(MODE_INSERT, fresh_handle(), pick_expiry());
        end else if (r < 34) begin
            send_cmd(MODE_INSERT, queued_handle(), pick_expiry());
        end else if (r < 50) begin
            send_cmd(MODE_ADJUST, queued_handle(), pick_expiry());
        end else if (r < 53) begin
            send_cmd(MODE_ADJUST, fresh_handle(), pick_expiry());
        end else if (r < 63) begin
            send_cmd(MODE_DELETE, queued_handle(), stamp_t'($urandom));
        end else if (r < 66) begin
            send_cmd(MODE_DELETE, fresh_handle(), stamp_t'($urandom));
        end else if (r < 90) begin
            now = now + $urandom_range(0, 300);
            send_cmd(MODE_TICK, handle_t'($urandom), now);
        end else if (r < 94) begin
            send_cmd(MODE_TICK, handle_t'($urandom), stamp_t'($urandom));
        end else if (r < 96) begin
            wait_all_results();
        end else if (r < 97) begin
            fill_then_drain();
        end else begin
            steady = !steady;
        end
    endtask

    initial begin : result_sink
        int hold;
        m_ready <= 1'b0;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (hold > 0) begin
                hold--;
            end else if (steady || !m_ready) begin
                m_ready <= 1'b1;
                hold = $urandom_range(0, 15);
            end else begin
                hold = pick_gap();
                if (hold > 0) begin
                    m_ready <= 1'b0;
                    hold--;
                end
            end
        end
    end

    initial begin : stimulus
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_payload <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, every mode, ties, adjust both ways, drain
        send_cmd(MODE_TICK,   '0, '0);                 // empty list, none expired
        send_cmd(MODE_DELETE, '0, '0);                 // not found
        send_cmd(MODE_ADJUST, '1, '1);                 // not found
        send_cmd(MODE_INSERT, '0, '0);
        send_cmd(MODE_INSERT, '1, '1);
        send_cmd(MODE_INSERT, 10'd5, 32'd100);
        send_cmd(MODE_INSERT, 10'd6, 32'd100);         // tie goes behind 5
        send_cmd(MODE_INSERT, 10'd5, 32'd7);           // duplicate
        send_cmd(MODE_ADJUST, '1, 32'd50);             // reduced expiry moves forward
        send_cmd(MODE_ADJUST, '0, 32'd200);            // raised expiry moves back
        send_cmd(MODE_ADJUST, 10'd5, 32'd100);         // same expiry requeues behind 6
        send_cmd(MODE_DELETE, 10'd6, '1);
        send_cmd(MODE_DELETE, 10'd6, '0);              // already gone
        send_cmd(MODE_TICK,   10'h2AA, 32'd49);        // nothing due yet
        send_cmd(MODE_TICK,   10'h155, 32'd100);       // two due at once
        send_cmd(MODE_TICK,   '1, '1);                 // drains the list
        send_cmd(MODE_TICK,   '0, '1);                 // empty after drain
        send_cmd(MODE_INSERT, 10'd3, 32'd10);          // reuse after drain
        send_cmd(MODE_INSERT, 10'd4, 32'd5);           // lands ahead of 3
        send_cmd(MODE_TICK,   '0, 32'd9);              // only 4 due
        send_cmd(MODE_DELETE, 10'd3, '0);              // empties by delete
        send_cmd(MODE_INSERT, 10'd3, 32'hAAAA_5555);
        wait_all_results();

        fill_then_drain();
        while (items_sent < TOTAL_ITEMS) random_timer_op();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (shadow.mismatches == 0 && shadow.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Hang guard, well above the slowest legal run.
    initial begin : watchdog
        #(64'd20_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ----- sorted_deadline_timer_queue.f -----
+incdir+design
design/sdtq_pkg.sv
design/sdtq_cell.sv
design/sorted_deadline_timer_queue.sv
test/tb_sorted_deadline_timer_queue.sv
